// ===== hdl/serprog_command_engine_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef SERPROG_COMMAND_ENGINE_UNIT_ASSERT_SVH
`define SERPROG_COMMAND_ENGINE_UNIT_ASSERT_SVH

// clocked assertion, muted while reset is applied
`define SCE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("serprog engine assertion failed");

// clocked assertion that also holds across reset
`define SCE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("serprog engine reset assertion failed");

`endif

// ===== hdl/sce_pkg.sv =====
package sce_pkg;

    // programmer name and command map sizes
    localparam int NAME_BYTES    = 16;
    localparam int CMD_MAP_BYTES = 32;

    // reply bytes
    localparam logic [7:0] ACK_BYTE  = 8'h06;
    localparam logic [7:0] NAK_BYTE  = 8'h15;
    localparam logic [7:0] MAP_BYTE0 = 8'h3F;
    localparam logic [7:0] MAP_BYTE2 = 8'h3D;
    localparam logic [7:0] IFACE_LO  = 8'h01;
    localparam logic [7:0] IFACE_HI  = 8'h00;
    localparam logic [7:0] BUF_BYTE  = 8'hFF;

    // host command codes
    localparam logic [7:0] CMD_NOP     = 8'h00;
    localparam logic [7:0] CMD_IFACE   = 8'h01;
    localparam logic [7:0] CMD_MAP     = 8'h02;
    localparam logic [7:0] CMD_NAME    = 8'h03;
    localparam logic [7:0] CMD_BUFSZ   = 8'h04;
    localparam logic [7:0] CMD_BUSTYPE = 8'h05;
    localparam logic [7:0] CMD_SYNC    = 8'h10;
    localparam logic [7:0] CMD_SETBUS  = 8'h12;
    localparam logic [7:0] CMD_SPIOP   = 8'h13;
    localparam logic [7:0] CMD_FREQ    = 8'h14;
    localparam logic [7:0] CMD_PIN     = 8'h15;

    // configuration register indexes
    localparam logic [1:0] CFG_NAME_LO  = 2'd0;
    localparam logic [1:0] CFG_NAME_HI  = 2'd1;
    localparam logic [1:0] CFG_BUS_MASK = 2'd2;
    localparam logic [1:0] CFG_SPI_HZ   = 2'd3;

    localparam logic [7:0]  BUS_MASK_RST = 8'h08;
    localparam logic [31:0] SPI_HZ_RST   = 32'd1000000;

    // input action codes
    localparam logic ACT_HOST = 1'b0;
    localparam logic ACT_MISO = 1'b1;

    typedef enum logic [1:0] {
        TGT_HOST = 2'd0,
        TGT_SPI  = 2'd1,
        TGT_CS   = 2'd2
    } t_target;

    typedef enum logic [3:0] {
        PH_IDLE, PH_BUS, PH_F1, PH_F2, PH_F3, PH_F4,
        PH_W0, PH_W1, PH_W2, PH_R0, PH_R1, PH_R2,
        PH_WBYTES, PH_RWAIT, PH_PIN
    } t_phase;

    // result sequences one host or miso byte can cause
    typedef enum logic [4:0] {
        B_ACK, B_NAK, B_IFACE, B_CMDMAP, B_NAME, B_BUFSZ, B_BUSTYPE,
        B_SYNC, B_FREQ, B_OPEN_END, B_OPEN_READ, B_OPEN, B_WR,
        B_WR_END, B_WR_READ, B_RD_NEXT, B_RD_END
    } t_burst;

    typedef struct packed {
        logic       go;
        t_burst     kind;
        logic [7:0] data;
    } t_burst_req;

    typedef struct packed {
        t_target    target;
        logic [7:0] payload;
        logic       wants;
    } t_result;

    // number of results in a sequence
    function automatic logic [5:0] burst_len(t_burst k);
        logic [5:0] n;
        case (k)
            B_ACK, B_NAK, B_OPEN, B_WR:          n = 6'd1;
            B_BUSTYPE, B_SYNC:                   n = 6'd2;
            B_RD_NEXT, B_RD_END:                 n = 6'd2;
            B_IFACE, B_BUFSZ:                    n = 6'd3;
            B_OPEN_END, B_OPEN_READ:             n = 6'd3;
            B_WR_END, B_WR_READ:                 n = 6'd3;
            B_FREQ:                              n = 6'd5;
            B_NAME:                              n = 6'(NAME_BYTES + 1);
            B_CMDMAP:                            n = 6'(CMD_MAP_BYTES + 1);
            default:                             n = 6'd1;
        endcase
        return n;
    endfunction

    // one result of a sequence, picked by its position
    function automatic t_result burst_elem(t_burst k, logic [5:0] idx, logic [7:0] b,
                                           logic [127:0] name, logic [7:0] mask,
                                           logic [31:0] hz);
        t_result    r;
        logic [3:0] nsel;
        logic [1:0] hsel;
        r.target  = TGT_HOST;
        r.payload = 8'h00;
        r.wants   = 1'b0;
        nsel      = idx[3:0] - 4'd1;
        hsel      = idx[1:0] - 2'd1;
        case (k)
            B_ACK: r.payload = ACK_BYTE;
            B_NAK: r.payload = NAK_BYTE;
            B_IFACE: begin
                if (idx == 6'd0) r.payload = ACK_BYTE;
                else if (idx == 6'd1) r.payload = IFACE_LO;
                else r.payload = IFACE_HI;
            end
            B_CMDMAP: begin
                if (idx == 6'd0) r.payload = ACK_BYTE;
                else if (idx == 6'd1) r.payload = MAP_BYTE0;
                else if (idx == 6'd3) r.payload = MAP_BYTE2;
                else r.payload = 8'h00;
            end
            B_NAME: begin
                if (idx == 6'd0) r.payload = ACK_BYTE;
                else r.payload = name[{nsel, 3'b000} +: 8];
            end
            B_BUFSZ: r.payload = (idx == 6'd0) ? ACK_BYTE : BUF_BYTE;
            B_BUSTYPE: r.payload = (idx == 6'd0) ? ACK_BYTE : mask;
            B_SYNC: r.payload = (idx == 6'd0) ? NAK_BYTE : ACK_BYTE;
            B_FREQ: begin
                if (idx == 6'd0) r.payload = ACK_BYTE;
                else r.payload = hz[{hsel, 3'b000} +: 8];
            end
            B_OPEN: begin
                r.target  = TGT_CS;
                r.payload = 8'h01;
            end
            B_OPEN_END, B_OPEN_READ: begin
                if (idx == 6'd0) begin
                    r.target  = TGT_CS;
                    r.payload = 8'h01;
                end else if (idx == 6'd1) begin
                    r.payload = ACK_BYTE;
                end else if (k == B_OPEN_END) begin
                    r.target = TGT_CS;
                end else begin
                    r.target = TGT_SPI;
                    r.wants  = 1'b1;
                end
            end
            B_WR: begin
                r.target  = TGT_SPI;
                r.payload = b;
            end
            B_WR_END, B_WR_READ: begin
                if (idx == 6'd0) begin
                    r.target  = TGT_SPI;
                    r.payload = b;
                end else if (idx == 6'd1) begin
                    r.payload = ACK_BYTE;
                end else if (k == B_WR_END) begin
                    r.target = TGT_CS;
                end else begin
                    r.target = TGT_SPI;
                    r.wants  = 1'b1;
                end
            end
            B_RD_NEXT, B_RD_END: begin
                if (idx == 6'd0) begin
                    r.payload = b;
                end else if (k == B_RD_END) begin
                    r.target = TGT_CS;
                end else begin
                    r.target = TGT_SPI;
                    r.wants  = 1'b1;
                end
            end
            default: r.payload = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sce_proto.sv =====
module sce_proto (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_action,
    input  logic [7:0]         i_data,
    input  logic [7:0]         i_bus_mask,
    output sce_pkg::t_burst_req o_burst
);
    import sce_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_freq_nz, n_freq_nz;
    logic [23:0] r_wlen, n_wlen;
    logic [23:0] r_rlen, n_rlen;
    logic [23:0] r_cnt, n_cnt;
    logic [23:0] rlen_full;
    t_burst_req  req;

    // protocol decode and next state
    always_comb begin
        n_phase   = r_phase;
        n_freq_nz = r_freq_nz;
        n_wlen    = r_wlen;
        n_rlen    = r_rlen;
        n_cnt     = r_cnt;
        rlen_full = {i_data, r_rlen[15:0]};
        req.go    = 1'b0;
        req.kind  = B_ACK;
        req.data  = i_data;
        if (i_action == ACT_MISO) begin
            if (r_phase == PH_RWAIT) begin
                req.go = 1'b1;
                if (r_cnt == 24'd1) begin
                    req.kind = B_RD_END;
                    n_phase  = PH_IDLE;
                end else begin
                    req.kind = B_RD_NEXT;
                    n_cnt    = r_cnt - 24'd1;
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    case (i_data)
                        CMD_NOP:     begin req.go = 1'b1; req.kind = B_ACK;     end
                        CMD_IFACE:   begin req.go = 1'b1; req.kind = B_IFACE;   end
                        CMD_MAP:     begin req.go = 1'b1; req.kind = B_CMDMAP;  end
                        CMD_NAME:    begin req.go = 1'b1; req.kind = B_NAME;    end
                        CMD_BUFSZ:   begin req.go = 1'b1; req.kind = B_BUFSZ;   end
                        CMD_BUSTYPE: begin req.go = 1'b1; req.kind = B_BUSTYPE; end
                        CMD_SYNC:    begin req.go = 1'b1; req.kind = B_SYNC;    end
                        CMD_SETBUS:  n_phase = PH_BUS;
                        CMD_SPIOP:   n_phase = PH_W0;
                        CMD_FREQ:    n_phase = PH_F1;
                        CMD_PIN:     n_phase = PH_PIN;
                        default:     begin req.go = 1'b1; req.kind = B_NAK;     end
                    endcase
                end
                PH_BUS: begin
                    req.go   = 1'b1;
                    req.kind = ((i_data & i_bus_mask) != 8'h00) ? B_ACK : B_NAK;
                    n_phase  = PH_IDLE;
                end
                PH_F1: begin
                    n_freq_nz = (i_data != 8'h00);
                    n_phase   = PH_F2;
                end
                PH_F2: begin
                    n_freq_nz = r_freq_nz | (i_data != 8'h00);
                    n_phase   = PH_F3;
                end
                PH_F3: begin
                    n_freq_nz = r_freq_nz | (i_data != 8'h00);
                    n_phase   = PH_F4;
                end
                PH_F4: begin
                    req.go   = 1'b1;
                    req.kind = (r_freq_nz | (i_data != 8'h00)) ? B_FREQ : B_NAK;
                    n_phase  = PH_IDLE;
                end
                PH_W0: begin n_wlen = {16'h0000, i_data};      n_phase = PH_W1; end
                PH_W1: begin n_wlen[15:8] = i_data;            n_phase = PH_W2; end
                PH_W2: begin n_wlen[23:16] = i_data;           n_phase = PH_R0; end
                PH_R0: begin n_rlen = {16'h0000, i_data};      n_phase = PH_R1; end
                PH_R1: begin n_rlen[15:8] = i_data;            n_phase = PH_R2; end
                PH_R2: begin
                    n_rlen = rlen_full;
                    req.go = 1'b1;
                    if (r_wlen == 24'd0) begin
                        if (rlen_full == 24'd0) begin
                            req.kind = B_OPEN_END;
                            n_phase  = PH_IDLE;
                        end else begin
                            req.kind = B_OPEN_READ;
                            n_cnt    = rlen_full;
                            n_phase  = PH_RWAIT;
                        end
                    end else begin
                        req.kind = B_OPEN;
                        n_cnt    = r_wlen;
                        n_phase  = PH_WBYTES;
                    end
                end
                PH_WBYTES: begin
                    req.go = 1'b1;
                    if (r_cnt == 24'd1) begin
                        if (r_rlen == 24'd0) begin
                            req.kind = B_WR_END;
                            n_phase  = PH_IDLE;
                        end else begin
                            req.kind = B_WR_READ;
                            n_cnt    = r_rlen;
                            n_phase  = PH_RWAIT;
                        end
                    end else begin
                        req.kind = B_WR;
                        n_cnt    = r_cnt - 24'd1;
                    end
                end
                PH_PIN: begin
                    req.go   = 1'b1;
                    req.kind = B_ACK;
                    n_phase  = PH_IDLE;
                end
                default: n_phase = r_phase;
            endcase
        end
        req.go = req.go & i_take;
    end

    assign o_burst = req;

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    // lengths, counter and frequency flag
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_freq_nz <= n_freq_nz;
            r_wlen    <= n_wlen;
            r_rlen    <= n_rlen;
            r_cnt     <= n_cnt;
        end
    end

endmodule

// ===== hdl/sce_emit.sv =====
module sce_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sce_pkg::t_burst_req i_burst,
    input  logic [127:0]        i_name,
    input  logic [7:0]          i_bus_mask,
    input  logic [31:0]         i_spi_hz,
    input  logic                i_m_ready,
    output logic                o_take_ok,
    output logic                o_m_valid,
    output sce_pkg::t_result    o_res,
    output logic                o_last
);
    import sce_pkg::*;

    logic       r_bvalid;
    t_burst     r_kind;
    logic [7:0] r_data;
    logic [5:0] r_idx;
    logic       r_ovalid;
    t_result    r_ores;
    logic       r_olast;
    logic       load;
    logic       last_elem;
    t_result    elem;

    // next result of the running sequence
    assign load      = r_bvalid && (!r_ovalid || i_m_ready);
    assign last_elem = (r_idx == (burst_len(r_kind) - 6'd1));
    assign elem      = burst_elem(r_kind, r_idx, r_data, i_name, i_bus_mask, i_spi_hz);
    assign o_take_ok = !r_bvalid || (load && last_elem);

    // sequence register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
        end else if (i_burst.go) begin
            r_bvalid <= 1'b1;
        end else if (load && last_elem) begin
            r_bvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.go) begin
            r_kind <= i_burst.kind;
            r_data <= i_burst.data;
            r_idx  <= 6'd0;
        end else if (load) begin
            r_idx  <= r_idx + 6'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ores  <= elem;
            r_olast <= last_elem;
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_res     = r_ores;
    assign o_last    = r_olast;

endmodule

// ===== hdl/serprog_command_engine_unit.sv =====
// channel   | direction | tdata          | tuser                      | tlast
// s_axis    | in        | [7:0] data     | [0] action                 | -
// m_axis    | out       | [7:0] payload  | [1:0] target, [2] wants    | last
// cfg       | in        | i_cfg_wdata    | i_cfg_addr selects reg     | -
//
// an item that causes n results holds the emitter until all n are loaded (n is 1 to 33, the
// command map reply being the longest); the next item is taken in the cycle
// the last result of the previous one enters the output register.
// items that cause at most one result flow at one per cycle while m_axis is not stalled.
// reset is synchronous, active low; it clears the phase, the sequence and
// output valid flags and restores the register defaults.
// a stall on m_axis holds the output register and backs up into s_axis_tready.
module serprog_command_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload
    output logic [2:0]  m_axis_tuser,   // [1:0] target, [2] wants_reply
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata
);
    import sce_pkg::*;

    logic [63:0] r_name_lo;
    logic [63:0] r_name_hi;
    logic [7:0]  r_bus_mask;
    logic [31:0] r_spi_hz;
    logic        take_ok;
    logic        take;
    t_burst_req  burst;
    t_result     res;
    logic        res_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_lo  <= 64'h0;
            r_name_hi  <= 64'h0;
            r_bus_mask <= BUS_MASK_RST;
            r_spi_hz   <= SPI_HZ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NAME_LO:  r_name_lo  <= i_cfg_wdata;
                CFG_NAME_HI:  r_name_hi  <= i_cfg_wdata;
                CFG_BUS_MASK: r_bus_mask <= i_cfg_wdata[7:0];
                CFG_SPI_HZ:   r_spi_hz   <= i_cfg_wdata[31:0];
                default:      r_spi_hz   <= r_spi_hz;
            endcase
        end
    end

    // input transaction
    assign s_axis_tready = take_ok;
    assign take          = s_axis_tvalid && take_ok;

    sce_proto u_proto (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_action   (s_axis_tuser[0]),
        .i_data     (s_axis_tdata),
        .i_bus_mask (r_bus_mask),
        .o_burst    (burst)
    );

    sce_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .i_name     ({r_name_hi, r_name_lo}),
        .i_bus_mask (r_bus_mask),
        .i_spi_hz   (r_spi_hz),
        .i_m_ready  (m_axis_tready),
        .o_take_ok  (take_ok),
        .o_m_valid  (m_axis_tvalid),
        .o_res      (res),
        .o_last     (res_last)
    );

    // output transaction fields
    assign m_axis_tdata = res.payload;
    assign m_axis_tuser = {res.wants, res.target};
    assign m_axis_tlast = res_last;

endmodule

// ===== hdl/sce_checker.sv =====
module sce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import sce_pkg::*;

`include "serprog_command_engine_unit_assert.svh"

    // a stalled result holds
    `SCE_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // nothing shown right after reset
    `SCE_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid)

    // target code stays in its range
    `SCE_ASSERT(a_target_range, m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)

    // a read request is a spi transfer with a zero byte
    `SCE_ASSERT(a_read_req, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == TGT_SPI && m_axis_tdata == 8'h00)

    // chip select carries a level only
    `SCE_ASSERT(a_cs_level, m_axis_tvalid && m_axis_tuser[1:0] == TGT_CS |-> m_axis_tdata[7:1] == 7'h00 && !m_axis_tuser[2])

endmodule

bind serprog_command_engine_unit sce_checker u_sce_checker (.*);
